### design/rbb_pkg.sv
`timescale 1ns / 1ps
package rbb_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_HALF   = 20;

  localparam int RST_SIZE = 1024;
  localparam int RST_HALF = 7;

  localparam int PIX_W   = 8;
  localparam int NCH     = 3;
  localparam int FW_SIZE = 11;
  localparam int FW_HALF = 5;
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_HALF_W = 2'd2,
    REG_HALF_H = 2'd3
  } rbb_reg_t;

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_DRAIN = 1'b1
  } rbb_action_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_PREP,
    S_LOAD,
    S_RUN,
    S_WAIT,
    S_FIN,
    S_SEND
  } rbb_state_t;

  // column sweep tag travelling alongside the lane data
  typedef struct packed {
    logic v;
    logic first;
    logic last;
  } rbb_tag_t;

endpackage

### design/rbb_stream_if.sv
`timescale 1ns / 1ps
interface rbb_in_if;
  import rbb_pkg::*;
  logic             valid;
  logic             ready;
  logic             action;
  logic [PIX_W-1:0] in_red;
  logic [PIX_W-1:0] in_green;
  logic [PIX_W-1:0] in_blue;
  modport source (output valid, action, in_red, in_green, in_blue, input ready);
  modport sink (input valid, action, in_red, in_green, in_blue, output ready);
endinterface

interface rbb_out_if;
  import rbb_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_red;
  logic [PIX_W-1:0] out_green;
  logic [PIX_W-1:0] out_blue;
  logic             last_in_run;
  logic             end_of_frame;
  modport source (output valid, out_red, out_green, out_blue, last_in_run, end_of_frame,
                  input ready);
  modport sink (input valid, out_red, out_green, out_blue, last_in_run, end_of_frame,
                output ready);
endinterface

### design/rbb_ram.sv
`timescale 1ns / 1ps
module rbb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### design/rbb_lane.sv
`timescale 1ns / 1ps
module rbb_lane #(
  parameter int LANE      = 0,
  parameter int NL        = 41,
  parameter int MAX_WIDTH = 1024,
  parameter int HW        = 5,
  parameter int WW        = 6,
  parameter int CW        = 14
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [$clog2(NL)-1:0]                 wr_slot,
  input  logic [$clog2(MAX_WIDTH)-1:0]          wr_addr,
  input  logic [rbb_pkg::NCH*rbb_pkg::PIX_W-1:0] wr_data,
  input  logic [$clog2(MAX_WIDTH)-1:0]          rd_addr,
  input  logic                                  wt_load,
  input  logic [$clog2(NL)-1:0]                 lo_slot,
  input  logic [$clog2(NL)-1:0]                 span,
  input  logic [HW-1:0]                         top_extra,
  input  logic [HW-1:0]                         bot_extra,
  output logic [rbb_pkg::NCH-1:0][CW-1:0]       prod
);
  import rbb_pkg::*;

  localparam int SLW = $clog2(NL);

  logic [NCH*PIX_W-1:0] rdata;
  logic [SLW:0]         off;
  logic [SLW:0]         lane_v;
  logic [WW-1:0]        weight_nxt;
  logic [WW-1:0]        weight_r;
  logic [NCH-1:0][CW-1:0] prod_r;

  rbb_ram #(.WIDTH(NCH*PIX_W), .DEPTH(MAX_WIDTH)) u_ram (
    .clk   (clk),
    .we    (wr_en && (wr_slot == SLW'(LANE))),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // weight = how many window rows land on the row held in this lane
  always_comb begin
    lane_v = (SLW+1)'(LANE);
    if (lane_v >= {1'b0, lo_slot}) begin
      off = lane_v - {1'b0, lo_slot};
    end else begin
      off = lane_v + (SLW+1)'(NL) - {1'b0, lo_slot};
    end
    weight_nxt = '0;
    if (off <= {1'b0, span}) begin
      weight_nxt = WW'(1);
      if (off == '0) begin
        weight_nxt = weight_nxt + WW'(top_extra);
      end
      if (off == {1'b0, span}) begin
        weight_nxt = weight_nxt + WW'(bot_extra);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wt_load) begin
      weight_r <= weight_nxt;
    end
    for (int c = 0; c < NCH; c++) begin
      prod_r[c] <= CW'(rdata[(NCH-1-c)*PIX_W +: PIX_W]) * CW'(weight_r);
    end
  end

  assign prod = prod_r;
endmodule

### design/rbb_merge.sv
`timescale 1ns / 1ps
module rbb_merge #(
  parameter int NL = 41,
  parameter int CW = 14,
  parameter int SW = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [NL-1:0][rbb_pkg::NCH-1:0][CW-1:0] prod,
  input  rbb_pkg::rbb_tag_t                   tag_in,
  output logic [rbb_pkg::NCH-1:0][SW-1:0]     sum,
  output logic                                done
);
  import rbb_pkg::*;

  localparam int N1 = (NL + 7) / 8;
  localparam int N2 = (N1 + 7) / 8;

  logic [N1-1:0][NCH-1:0][CW-1:0] s1_nxt, s1_r;
  logic [N2-1:0][NCH-1:0][CW-1:0] s2_nxt, s2_r;
  logic [NCH-1:0][CW-1:0]         s3_nxt, s3_r;
  logic [NCH-1:0][SW-1:0]         acc_r;
  rbb_tag_t                       t1_r, t2_r, t3_r;
  logic                           done_r;

  // three registered adder levels: two of eight-way adds, then one summing the rest
  always_comb begin
    for (int g = 0; g < N1; g++) begin
      for (int c = 0; c < NCH; c++) begin
        s1_nxt[g][c] = '0;
        for (int j = 0; j < 8; j++) begin
          if (g*8 + j < NL) begin
            s1_nxt[g][c] = s1_nxt[g][c] + prod[g*8 + j][c];
          end
        end
      end
    end
    for (int g = 0; g < N2; g++) begin
      for (int c = 0; c < NCH; c++) begin
        s2_nxt[g][c] = '0;
        for (int j = 0; j < 8; j++) begin
          if (g*8 + j < N1) begin
            s2_nxt[g][c] = s2_nxt[g][c] + s1_r[g*8 + j][c];
          end
        end
      end
    end
    for (int c = 0; c < NCH; c++) begin
      s3_nxt[c] = '0;
      for (int j = 0; j < N2; j++) begin
        s3_nxt[c] = s3_nxt[c] + s2_r[j][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    s2_r <= s2_nxt;
    s3_r <= s3_nxt;
    if (t3_r.v) begin
      for (int c = 0; c < NCH; c++) begin
        acc_r[c] <= t3_r.first ? SW'(s3_r[c]) : acc_r[c] + SW'(s3_r[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r   <= '0;
      t2_r   <= '0;
      t3_r   <= '0;
      done_r <= 1'b0;
    end else begin
      t1_r   <= tag_in;
      t2_r   <= t1_r;
      t3_r   <= t2_r;
      done_r <= t3_r.v && t3_r.last;
    end
  end

  assign sum  = acc_r;
  assign done = done_r;
endmodule

### design/rbb_div.sv
`timescale 1ns / 1ps
module rbb_div #(
  parameter int SW = 20,
  parameter int AW = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [rbb_pkg::NCH-1:0][SW-1:0]      num,
  input  logic [AW-1:0]                        area,
  output logic [rbb_pkg::NCH-1:0][rbb_pkg::PIX_W-1:0] quo,
  output logic                                 done
);
  import rbb_pkg::*;

  localparam int NB  = SW + 1;
  localparam int CNW = $clog2(NB + 1);

  logic [NCH-1:0][NB-1:0] dvd_r, dvd_nxt;
  logic [NCH-1:0][AW-1:0] rem_r, rem_nxt;
  logic [AW-1:0]          area_r;
  logic [CNW-1:0]         cnt_r;
  logic                   busy_r, done_r;
  logic [AW:0]            trial, diff;

  // restoring division, one quotient bit per cycle for all channels
  always_comb begin
    trial = '0;
    diff  = '0;
    for (int c = 0; c < NCH; c++) begin
      trial = {rem_r[c], dvd_r[c][NB-1]};
      diff  = trial - {1'b0, area_r};
      if (trial >= {1'b0, area_r}) begin
        rem_nxt[c] = diff[AW-1:0];
        dvd_nxt[c] = {dvd_r[c][NB-2:0], 1'b1};
      end else begin
        rem_nxt[c] = trial[AW-1:0];
        dvd_nxt[c] = {dvd_r[c][NB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      area_r <= area;
      for (int c = 0; c < NCH; c++) begin
        dvd_r[c] <= NB'(num[c]) + NB'(area >> 1);
        rem_r[c] <= '0;
      end
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNW'(NB);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNW'(1);
        if (cnt_r == CNW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      quo[c] = dvd_r[c][PIX_W-1:0];
    end
  end

  assign done = done_r;
endmodule

### design/rgb_box_blur_replicate_border_unit.sv
`timescale 1ns / 1ps
// Streaming RGB box blur with replicated borders. Pixels enter in raster
// order; each result is the rounded mean of a (2h+1) x (2w+1) window, and
// results leave in raster order, lagging the input by h rows and w columns.
// The last 2*MAX_HALF+1 rows sit in row RAMs, one per lane. For a result,
// every lane gets a weight (how many window rows fall on its stored row,
// counting the replicated top and bottom rows), then the block sweeps the
// 2w+1 window columns, one column per cycle, with the column index clamped
// to the frame; all lanes read and multiply in parallel and an 8-way adder
// tree merges them. A bit-serial divider then forms the three means.
// A new request is taken only after all results of the previous one have
// been delivered. A drain request flushes one pending result after the last
// pixel of a frame. Writing any register restarts the frame.
module rgb_box_blur_replicate_border_unit #(
  parameter int MAX_WIDTH  = rbb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rbb_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_HALF   = rbb_pkg::DEF_MAX_HALF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  rbb_in_if.sink                      in_ch,
  rbb_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rbb_pkg::CFG_AW-1:0]  paddr,
  input  logic [rbb_pkg::CFG_DW-1:0]  pwdata,
  output logic [rbb_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import rbb_pkg::*;

  localparam int NL  = 2 * MAX_HALF + 1;
  localparam int SLW = $clog2(NL);
  localparam int CLW = $clog2(MAX_WIDTH);
  localparam int RLW = $clog2(MAX_HEIGHT);
  localparam int WDW = $clog2(MAX_WIDTH + 1);
  localparam int HTW = $clog2(MAX_HEIGHT + 1);
  localparam int HW  = $clog2(MAX_HALF + 1);
  localparam int WW  = $clog2(NL + 1);
  localparam int CW  = PIX_W + WW;
  localparam int SW  = PIX_W + 2 * WW;
  localparam int AW  = 2 * WW;
  localparam int NW  = $clog2(MAX_WIDTH + MAX_HALF + 1);
  localparam int RNW = $clog2(MAX_HEIGHT + MAX_HALF + 1);
  localparam int CSW = NW + 1;
  localparam int RST_W  = (RST_SIZE > MAX_WIDTH) ? MAX_WIDTH : RST_SIZE;
  localparam int RST_H  = (RST_SIZE > MAX_HEIGHT) ? MAX_HEIGHT : RST_SIZE;
  localparam int RST_HF = (RST_HALF > MAX_HALF) ? MAX_HALF : RST_HALF;

  rbb_state_t state_r, state_nxt;

  // configuration
  logic [WDW-1:0] width_r, width_nxt;
  logic [HTW-1:0] height_r, height_nxt;
  logic [HW-1:0]  hw_r, hw_nxt, hh_r, hh_nxt;

  // frame position
  logic [CLW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [RLW-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [SLW-1:0] in_slot_r, in_slot_nxt, out_slot_r, out_slot_nxt;
  logic           in_done_r, in_done_nxt, out_done_r, out_done_nxt;

  // request being served
  logic [CLW-1:0] item_col_r, item_col_nxt;
  logic [RLW-1:0] item_row_r, item_row_nxt;
  logic           drain_r, drain_nxt;

  // per-result job
  logic [SLW-1:0] lo_slot_r, lo_slot_nxt, span_r, span_nxt;
  logic [HW-1:0]  top_r, top_nxt, bot_r, bot_nxt;
  logic [AW-1:0]  area_r, area_nxt;
  logic signed [CSW-1:0] cur_col_r, cur_col_nxt;
  logic [HW:0]    k_r, k_nxt;

  // result register
  logic [NCH-1:0][PIX_W-1:0] pix_r, pix_nxt;
  logic                      eof_r, eof_nxt;

  logic           in_acc, cfg_wr;
  logic [CLW-1:0] eff_col;
  logic [RLW-1:0] eff_row;
  logic [SLW-1:0] eff_slot;
  logic [NW-1:0]  need, wm1;
  logic [RNW-1:0] hm1, row_reach;
  logic           cond;
  logic [HW-1:0]  dist_up, down;
  logic [SLW:0]   lo_calc;
  logic [HW:0]    two_w;
  logic [CLW-1:0] rd_addr;
  rbb_tag_t       tag_issue, tag_d1_r, tag_d2_r;
  logic [NL-1:0][NCH-1:0][CW-1:0] prod;
  logic [NCH-1:0][SW-1:0]         col_sum;
  logic           sum_done, div_done;
  logic [NCH-1:0][PIX_W-1:0]      quo;
  logic [FW_SIZE-1:0] wsz;
  logic [FW_HALF-1:0] whf;
  logic [WDW-1:0] cl_w;
  logic [HTW-1:0] cl_h;
  logic [HW-1:0]  cl_hf;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign in_ch.ready = (state_r == S_IDLE);

  // a pixel after a finished frame starts a new one at the origin
  assign eff_col  = in_done_r ? '0 : in_col_r;
  assign eff_row  = in_done_r ? '0 : in_row_r;
  assign eff_slot = in_done_r ? '0 : in_slot_r;

  // next result is ready when its window's last column has arrived
  always_comb begin
    wm1       = NW'(width_r - WDW'(1));
    hm1       = RNW'(height_r - HTW'(1));
    need      = NW'(out_col_r) + NW'(hw_r);
    if (need > wm1) begin
      need = wm1;
    end
    row_reach = RNW'(out_row_r) + RNW'(hh_r);
    cond = !out_done_r && (row_reach == RNW'(item_row_r)) && (need <= NW'(item_col_r));
  end

  // row span of the window, clipped to the frame
  always_comb begin
    dist_up = (RNW'(out_row_r) >= RNW'(hh_r)) ? hh_r : HW'(out_row_r);
    down    = (row_reach > hm1) ? HW'(hm1 - RNW'(out_row_r)) : hh_r;
    if ({1'b0, out_slot_r} >= (SLW+1)'(dist_up)) begin
      lo_calc = {1'b0, out_slot_r} - (SLW+1)'(dist_up);
    end else begin
      lo_calc = {1'b0, out_slot_r} + (SLW+1)'(NL) - (SLW+1)'(dist_up);
    end
  end

  // clamp the swept column into the frame
  always_comb begin
    two_w = {hw_r, 1'b0};
    if (cur_col_r[CSW-1]) begin
      rd_addr = '0;
    end else if (cur_col_r[NW-1:0] > wm1) begin
      rd_addr = CLW'(wm1);
    end else begin
      rd_addr = CLW'(cur_col_r[NW-1:0]);
    end
    tag_issue.v     = (state_r == S_RUN);
    tag_issue.first = (k_r == '0);
    tag_issue.last  = (k_r == two_w);
  end

  // register write value, out of range sizes saturated, a zero size raised to one
  always_comb begin
    wsz = pwdata[FW_SIZE-1:0];
    whf = pwdata[FW_HALF-1:0];
    if (32'(wsz) > 32'(MAX_WIDTH)) begin
      cl_w = WDW'(MAX_WIDTH);
    end else if (wsz == '0) begin
      cl_w = WDW'(1);
    end else begin
      cl_w = WDW'(wsz);
    end
    if (32'(wsz) > 32'(MAX_HEIGHT)) begin
      cl_h = HTW'(MAX_HEIGHT);
    end else if (wsz == '0) begin
      cl_h = HTW'(1);
    end else begin
      cl_h = HTW'(wsz);
    end
    if (32'(whf) > 32'(MAX_HALF)) begin
      cl_hf = HW'(MAX_HALF);
    end else begin
      cl_hf = HW'(whf);
    end
  end

  always_comb begin
    case (rbb_reg_t'(paddr[3:2]))
      REG_WIDTH:  prdata = CFG_DW'(width_r);
      REG_HEIGHT: prdata = CFG_DW'(height_r);
      REG_HALF_W: prdata = CFG_DW'(hw_r);
      REG_HALF_H: prdata = CFG_DW'(hh_r);
      default:    prdata = '0;
    endcase
  end

  // next state and datapath control
  always_comb begin
    state_nxt    = state_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    hw_nxt       = hw_r;
    hh_nxt       = hh_r;
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    in_slot_nxt  = in_slot_r;
    in_done_nxt  = in_done_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    out_slot_nxt = out_slot_r;
    out_done_nxt = out_done_r;
    item_col_nxt = item_col_r;
    item_row_nxt = item_row_r;
    drain_nxt    = drain_r;
    lo_slot_nxt  = lo_slot_r;
    span_nxt     = span_r;
    top_nxt      = top_r;
    bot_nxt      = bot_r;
    area_nxt     = area_r;
    cur_col_nxt  = cur_col_r;
    k_nxt        = k_r;
    pix_nxt      = pix_r;
    eof_nxt      = eof_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.action == ACT_DRAIN) begin
            if (in_done_r && !out_done_r) begin
              drain_nxt = 1'b1;
              state_nxt = S_PREP;
            end
          end else begin
            if (in_done_r) begin
              out_col_nxt  = '0;
              out_row_nxt  = '0;
              out_slot_nxt = '0;
              out_done_nxt = 1'b0;
            end
            drain_nxt    = 1'b0;
            item_col_nxt = eff_col;
            item_row_nxt = eff_row;
            in_done_nxt  = 1'b0;
            in_col_nxt   = eff_col + CLW'(1);
            in_row_nxt   = eff_row;
            in_slot_nxt  = eff_slot;
            if (WDW'(eff_col) + WDW'(1) >= width_r) begin
              in_col_nxt = '0;
              if (HTW'(eff_row) + HTW'(1) >= height_r) begin
                in_row_nxt  = '0;
                in_slot_nxt = '0;
                in_done_nxt = 1'b1;
              end else begin
                in_row_nxt  = eff_row + RLW'(1);
                in_slot_nxt = (eff_slot == SLW'(NL - 1)) ? '0 : eff_slot + SLW'(1);
              end
            end
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        state_nxt = cond ? S_PREP : S_IDLE;
      end
      S_PREP: begin
        lo_slot_nxt = lo_calc[SLW-1:0];
        span_nxt    = SLW'(dist_up) + SLW'(down);
        top_nxt     = hh_r - dist_up;
        bot_nxt     = hh_r - down;
        area_nxt    = AW'({hw_r, 1'b1}) * AW'({hh_r, 1'b1});
        state_nxt   = S_LOAD;
      end
      S_LOAD: begin
        cur_col_nxt = $signed({1'b0, NW'(out_col_r)}) - $signed({1'b0, NW'(hw_r)});
        k_nxt       = '0;
        state_nxt   = S_RUN;
      end
      S_RUN: begin
        cur_col_nxt = cur_col_r + CSW'(1);
        k_nxt       = k_r + (HW+1)'(1);
        if (k_r == two_w) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        pix_nxt = quo;
        eof_nxt = (HTW'(out_row_r) + HTW'(1) == height_r) &&
                  (WDW'(out_col_r) + WDW'(1) == width_r);
        out_col_nxt = out_col_r + CLW'(1);
        if (WDW'(out_col_r) + WDW'(1) >= width_r) begin
          out_col_nxt = '0;
          if (HTW'(out_row_r) + HTW'(1) >= height_r) begin
            out_row_nxt  = '0;
            out_slot_nxt = '0;
            out_done_nxt = 1'b1;
          end else begin
            out_row_nxt  = out_row_r + RLW'(1);
            out_slot_nxt = (out_slot_r == SLW'(NL - 1)) ? '0 : out_slot_r + SLW'(1);
          end
        end
        state_nxt = S_SEND;
      end
      S_SEND: begin
        if (out_ch.ready) begin
          state_nxt = (drain_r || !cond) ? S_IDLE : S_PREP;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // any register write restarts the frame
    if (cfg_wr) begin
      in_col_nxt   = '0;
      in_row_nxt   = '0;
      in_slot_nxt  = '0;
      in_done_nxt  = 1'b0;
      out_col_nxt  = '0;
      out_row_nxt  = '0;
      out_slot_nxt = '0;
      out_done_nxt = 1'b0;
      case (rbb_reg_t'(paddr[3:2]))
        REG_WIDTH:  width_nxt  = cl_w;
        REG_HEIGHT: height_nxt = cl_h;
        REG_HALF_W: hw_nxt     = cl_hf;
        REG_HALF_H: hh_nxt     = cl_hf;
        default:    width_nxt  = width_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      width_r    <= WDW'(RST_W);
      height_r   <= HTW'(RST_H);
      hw_r       <= HW'(RST_HF);
      hh_r       <= HW'(RST_HF);
      in_col_r   <= '0;
      in_row_r   <= '0;
      in_slot_r  <= '0;
      in_done_r  <= 1'b0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_slot_r <= '0;
      out_done_r <= 1'b0;
      drain_r    <= 1'b0;
      tag_d1_r   <= '0;
      tag_d2_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      hw_r       <= hw_nxt;
      hh_r       <= hh_nxt;
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      in_slot_r  <= in_slot_nxt;
      in_done_r  <= in_done_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      out_slot_r <= out_slot_nxt;
      out_done_r <= out_done_nxt;
      drain_r    <= drain_nxt;
      tag_d1_r   <= tag_issue;
      tag_d2_r   <= tag_d1_r;
    end
  end

  always_ff @(posedge clk) begin
    item_col_r <= item_col_nxt;
    item_row_r <= item_row_nxt;
    lo_slot_r  <= lo_slot_nxt;
    span_r     <= span_nxt;
    top_r      <= top_nxt;
    bot_r      <= bot_nxt;
    area_r     <= area_nxt;
    cur_col_r  <= cur_col_nxt;
    k_r        <= k_nxt;
    pix_r      <= pix_nxt;
    eof_r      <= eof_nxt;
  end

  // one lane per stored row
  for (genvar l = 0; l < NL; l++) begin : g_lane
    rbb_lane #(
      .LANE      (l),
      .NL        (NL),
      .MAX_WIDTH (MAX_WIDTH),
      .HW        (HW),
      .WW        (WW),
      .CW        (CW)
    ) u_lane (
      .clk       (clk),
      .wr_en     (in_acc && (in_ch.action == ACT_PIXEL)),
      .wr_slot   (eff_slot),
      .wr_addr   (eff_col),
      .wr_data   ({in_ch.in_red, in_ch.in_green, in_ch.in_blue}),
      .rd_addr   (rd_addr),
      .wt_load   (state_r == S_LOAD),
      .lo_slot   (lo_slot_r),
      .span      (span_r),
      .top_extra (top_r),
      .bot_extra (bot_r),
      .prod      (prod[l])
    );
  end

  rbb_merge #(.NL(NL), .CW(CW), .SW(SW)) u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .prod   (prod),
    .tag_in (tag_d2_r),
    .sum    (col_sum),
    .done   (sum_done)
  );

  rbb_div #(.SW(SW), .AW(AW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sum_done),
    .num   (col_sum),
    .area  (area_r),
    .quo   (quo),
    .done  (div_done)
  );

  assign out_ch.valid        = (state_r == S_SEND);
  assign out_ch.out_red      = pix_r[0];
  assign out_ch.out_green    = pix_r[1];
  assign out_ch.out_blue     = pix_r[2];
  assign out_ch.last_in_run  = drain_r || !cond;
  assign out_ch.end_of_frame = eof_r;
endmodule
